@@ design/pti_pkg.sv @@
// Shared types, constants and codes of the piecewise table interpolator.
package pti_pkg;

  localparam int PTI_MAX_POINTS = 1024;
  localparam int PTI_QDEPTH     = 2;

  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 11;
  localparam int IN_TW   = 112;
  localparam int OUT_TW  = 40;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_INTERP_MODE = 1'b1;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] xv;
    logic [VAL_W-1:0] yv;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

@@ design/pti_front.sv @@
// Input side: accepts transfers, classifies them and holds them in a short queue.
module pti_front
  import pti_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,
  input  logic              in_tuser,
  output queue_out_t        q_out,
  input  logic              q_ready
);

  localparam int PW = $clog2(PTI_QDEPTH);

  item_t           slot_r [PTI_QDEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW:0]     count_r;
  item_t           item_in;
  logic            push;
  logic            pop;

  always_comb begin
    item_in.op  = in_tuser;
    item_in.idx = in_tdata[9:0];
    if (in_tuser == OP_LOOKUP) begin
      item_in.xv = in_tdata[105:74];
      item_in.yv = '0;
    end else begin
      item_in.xv = in_tdata[41:10];
      item_in.yv = in_tdata[73:42];
    end
  end

  assign in_tready   = (count_r != (PW+1)'(PTI_QDEPTH));
  assign push        = in_tvalid && in_tready;
  assign q_out.valid = (count_r != '0);
  assign q_out.item  = slot_r[rd_ptr_r];
  assign pop         = q_out.valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

@@ design/pti_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module pti_div
  import pti_pkg::*;
#(
  parameter int DW = 66,
  parameter int VW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          qbit;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DW-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    qbit    = (rem_sh >= {1'b0, dvs_r});
  end

  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], qbit};
      rem_r <= qbit ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/pti_back.sv @@
// Back end: table memory, bracket search, interpolation and result register.
module pti_back
  import pti_pkg::*;
#(
  parameter int MAX_POINTS = PTI_MAX_POINTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  queue_out_t        q_in,
  output logic              q_ready,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [CNT_W-1:0]  cfg_wdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int DW = 66;
  localparam int VW = 33;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDL, ST_CHK, ST_SPROBE, ST_SCMP, ST_FETCH, ST_FETCH1, ST_FETCH2,
    ST_CALC, ST_MUL0, ST_MUL1, ST_DIVS, ST_DIVW, ST_SUM, ST_RESULT
  } state_t;

  logic [VAL_W-1:0] x_mem [MAX_POINTS];
  logic [VAL_W-1:0] y_mem [MAX_POINTS];

  state_t             state_r;
  logic [CNT_W-1:0]   pcount_r;
  logic               mode_r;
  logic [VAL_W-1:0]   rd_x_r;
  logic [VAL_W-1:0]   rd_y_r;
  logic signed [VAL_W-1:0] v_r;
  logic [VAL_W-1:0]   xa_r, ya_r, xb_r, yb_r;
  logic [NW-1:0]      lo_r, cnt_r;
  logic [AW-1:0]      k_r;
  logic [VW-1:0]      mdx_r, mt_r, mdy_r;
  logic               neg_r;
  logic [DW-1:0]      acc_r;
  logic [34:0]        q_r;
  logic [VAL_W-1:0]   res_r;
  logic               dive_r, sat_r;
  logic               ovalid_r;
  logic [VAL_W-1:0]   ores_r;
  logic               odiv_r, osat_r;

  logic [NW-1:0]      n, last, half, lo_nxt, cnt_nxt, km1, kcl;
  logic [AW-1:0]      raddr, waddr;
  logic               wr_en, div_start, div_done;
  logic [DW-1:0]      quotient;
  logic signed [VW-1:0] dx, tt, dy;
  logic signed [35:0] sum;

  always_comb begin
    if (pcount_r == '0) begin
      n = NW'(1);
    end else if (32'(pcount_r) > 32'(MAX_POINTS)) begin
      n = NW'(MAX_POINTS);
    end else begin
      n = NW'(pcount_r);
    end
    last = n - 1'b1;
    half = cnt_r >> 1;
    if ($signed(rd_x_r) < v_r) begin
      lo_nxt  = lo_r + half + 1'b1;
      cnt_nxt = cnt_r - half - 1'b1;
    end else begin
      lo_nxt  = lo_r;
      cnt_nxt = half;
    end
    km1 = lo_nxt - 1'b1;
    kcl = (km1 > last - 1'b1) ? last - 1'b1 : km1;
    case (state_r)
      ST_RDL:    raddr = AW'(last);
      ST_SPROBE: raddr = AW'(lo_r + half);
      ST_FETCH:  raddr = k_r;
      ST_FETCH1: raddr = k_r + 1'b1;
      default:   raddr = '0;
    endcase
    dx  = $signed({xb_r[31], xb_r}) - $signed({xa_r[31], xa_r});
    tt  = $signed({v_r[31], v_r}) - $signed({xa_r[31], xa_r});
    dy  = $signed({yb_r[31], yb_r}) - $signed({ya_r[31], ya_r});
    sum = neg_r ? $signed({{4{ya_r[31]}}, ya_r}) - $signed({1'b0, q_r})
                : $signed({{4{ya_r[31]}}, ya_r}) + $signed({1'b0, q_r});
  end

  assign q_ready   = (state_r == ST_IDLE);
  assign wr_en     = q_in.valid && q_ready && (q_in.item.op == OP_WRITE) &&
                     (32'(q_in.item.idx) < 32'(MAX_POINTS));
  assign waddr     = AW'(q_in.item.idx);
  assign div_start = (state_r == ST_DIVS);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[waddr] <= q_in.item.xv;
      y_mem[waddr] <= q_in.item.yv;
    end
    rd_x_r <= x_mem[raddr];
    rd_y_r <= y_mem[raddr];
  end

  pti_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r + DW'(mdx_r >> 1)),
    .divisor  (mdx_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'd0, osat_r, odiv_r, ores_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pcount_r <= CNT_W'(1);
      mode_r   <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_POINT_COUNT: pcount_r <= cfg_wdata;
          CFG_INTERP_MODE: mode_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (ovalid_r && out_tready && (state_r != ST_RESULT)) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_in.valid && q_in.item.op == OP_LOOKUP) begin
            v_r     <= $signed(q_in.item.xv);
            dive_r  <= 1'b0;
            sat_r   <= 1'b0;
            state_r <= ST_RDL;
          end
        end
        ST_RDL: begin
          xa_r    <= rd_x_r;
          ya_r    <= rd_y_r;
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (last == '0) begin
            res_r   <= ya_r;
            state_r <= ST_RESULT;
          end else if (v_r < $signed(xa_r)) begin
            k_r     <= '0;
            res_r   <= ya_r;
            state_r <= mode_r ? ST_FETCH : ST_RESULT;
          end else if (v_r > $signed(rd_x_r)) begin
            k_r     <= AW'(last - 1'b1);
            res_r   <= rd_y_r;
            state_r <= mode_r ? ST_FETCH : ST_RESULT;
          end else if (v_r == $signed(xa_r)) begin
            k_r     <= '0;
            state_r <= ST_FETCH;
          end else begin
            lo_r    <= '0;
            cnt_r   <= n;
            state_r <= ST_SPROBE;
          end
        end
        ST_SPROBE: begin
          state_r <= ST_SCMP;
        end
        ST_SCMP: begin
          lo_r  <= lo_nxt;
          cnt_r <= cnt_nxt;
          if (cnt_nxt == '0) begin
            k_r     <= AW'(kcl);
            state_r <= ST_FETCH;
          end else begin
            state_r <= ST_SPROBE;
          end
        end
        ST_FETCH: begin
          state_r <= ST_FETCH1;
        end
        ST_FETCH1: begin
          xa_r    <= rd_x_r;
          ya_r    <= rd_y_r;
          state_r <= ST_FETCH2;
        end
        ST_FETCH2: begin
          xb_r    <= rd_x_r;
          yb_r    <= rd_y_r;
          res_r   <= rd_y_r;
          state_r <= mode_r ? ST_CALC : ST_RESULT;
        end
        ST_CALC: begin
          mdx_r <= dx[VW-1] ? VW'(-dx) : VW'(dx);
          mt_r  <= tt[VW-1] ? VW'(-tt) : VW'(tt);
          mdy_r <= dy[VW-1] ? VW'(-dy) : VW'(dy);
          neg_r <= tt[VW-1] ^ dy[VW-1] ^ dx[VW-1];
          if (dx == '0) begin
            res_r   <= ya_r;
            dive_r  <= 1'b1;
            state_r <= ST_RESULT;
          end else begin
            state_r <= ST_MUL0;
          end
        end
        ST_MUL0: begin
          acc_r   <= DW'(mt_r * mdy_r[16:0]);
          state_r <= ST_MUL1;
        end
        ST_MUL1: begin
          acc_r   <= acc_r + (DW'(mt_r * mdy_r[32:17]) << 17);
          state_r <= ST_DIVS;
        end
        ST_DIVS: begin
          state_r <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) begin
            q_r     <= (quotient > DW'(35'h4_0000_0000)) ? 35'h4_0000_0000
                                                         : quotient[34:0];
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (sum > 36'sd2147483647) begin
            res_r <= 32'h7FFF_FFFF;
            sat_r <= 1'b1;
          end else if (sum < -36'sd2147483648) begin
            res_r <= 32'h8000_0000;
            sat_r <= 1'b1;
          end else begin
            res_r <= sum[31:0];
          end
          state_r <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!ovalid_r || out_tready) begin
            ovalid_r <= 1'b1;
            ores_r   <= res_r;
            odiv_r   <= dive_r;
            osat_r   <= sat_r;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/piecewise_table_interpolator.sv @@
// Top level of the piecewise table interpolator: front queue and back end.
//
//   Channel  Direction  Contents
//   in_      slave      tuser: opcode; tdata: point_index, point_x, point_y, query_value
//   out_     master     tdata: result_value, divide_error, saturated
//   cfg_     write      index 0 point_count, index 1 interp_mode
//
// A write transfer updates the table as it leaves the queue.
// A lookup needs no bracket search for a one-point table or a step query outside the
// table; other lookups may search up to 11 steps for 1024 points before a fetch.
// Linear mode then multiplies and waits on the 66-step bit-serial divider, or skips
// the divider when the bracketing x values are equal.
// Reset is synchronous and clears the queue, the sequencer and out_tvalid.
// The two-entry queue accepts transfers while the back end or out_ stalls, until it is full.
module piecewise_table_interpolator
  import pti_pkg::*;
#(
  parameter int MAX_POINTS = PTI_MAX_POINTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // point_index, point_x, point_y, query_value, zeros
  input  logic              in_tuser,   // opcode
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata,  // result_value, divide_error, saturated, zeros
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [CNT_W-1:0]  cfg_wdata
);

  queue_out_t q_bus;
  logic       q_ready;

  pti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_out     (q_bus),
    .q_ready   (q_ready)
  );

  pti_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_in       (q_bus),
    .q_ready    (q_ready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ design/pti_checker.sv @@
// Port checker for the piecewise table interpolator, bound to the top level.
module pti_checker
  import pti_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [IN_TW-1:0]  in_tdata,
  input logic              in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_TW-1:0] out_tdata,
  input logic              cfg_we,
  input logic              cfg_addr,
  input logic [CNT_W-1:0]  cfg_wdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed.");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result present after reset.");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[32] && out_tdata[33]))
    else $error("Divide error and saturation set together.");

endmodule

bind piecewise_table_interpolator pti_checker u_pti_checker (.*);
